// File: rtl/core/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Types and codes shared by the byte ring FIFO blocks.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Largest ring the 9-bit size register can select.
  localparam int SIZE_W   = 9;
  localparam int SIZE_MAX = 511;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] data_in;
    logic [7:0] peek_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              accepted;
    logic [SIZE_W-1:0] fill_count;
    logic [SIZE_W-1:0] free_count;
    logic              is_full;
  } out_item_t;

  // Result fields known at accept time; the byte itself comes from the store.
  typedef struct packed {
    logic              accepted;
    logic [SIZE_W-1:0] fill_count;
    logic [SIZE_W-1:0] free_count;
    logic              is_full;
    logic              use_mem;
  } res_info_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

// File: rtl/core/byte_ring_fifo_with_peek_top.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_top
// Byte ring FIFO with push, pop, peek-at-offset and clear requests.
// ----------------------------------------------------------------------------
// Results: each is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless sweeping or the output stalls; the
//   single result register refills in the cycle it is taken, and the store
//   has one write and one read port. Reset: pointers and fill clear at
//   once, size returns to 256; the store is then zeroed by a sweep of
//   min(DEPTH, 511) cells with in_ready low; size writes are taken during it.
module byte_ring_fifo_with_peek_top import brf_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  // Cells past what the size register can reach are never addressed.
  localparam int WORDS = (DEPTH < SIZE_MAX) ? DEPTH : SIZE_MAX;
  localparam int AW    = $clog2(WORDS);

  logic          accept;
  logic          busy;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  res_info_t     info, res;

  // Result register frees up in the same cycle it is taken downstream.
  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  brf_ctrl #(.WORDS(WORDS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (in_data),
    .cfg_we   (cfg_wr_en),
    .cfg_data (cfg_wr_data),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .raddr    (raddr),
    .info     (info)
  );

  // Read data register doubles as the byte field of the result.
  brf_store #(.WORDS(WORDS)) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (in_data.data_in),
    .raddr (raddr),
    .rdata (rdata),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= info;
  end

  // Push, clear and an empty pop report a zero byte.
  assign out_data.data_out   = res.use_mem ? rdata : 8'd0;
  assign out_data.accepted   = res.accepted;
  assign out_data.fill_count = res.fill_count;
  assign out_data.free_count = res.free_count;
  assign out_data.is_full    = res.is_full;

endmodule

// File: rtl/core/brf_store.sv
// ----------------------------------------------------------------------------
// brf_store
// Byte store: one write and one registered read port, zeroed by a sweep
// after reset.
// ----------------------------------------------------------------------------
module brf_store import brf_pkg::*; #(
  parameter int WORDS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mem_ctl_t                   ctl,
  input  logic [$clog2(WORDS)-1:0]   waddr,
  input  logic [7:0]                 wdata,
  input  logic [$clog2(WORDS)-1:0]   raddr,
  output logic [7:0]                 rdata,
  output logic                       busy
);

  localparam int AW = $clog2(WORDS);
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

  logic [7:0]    mem [WORDS];
  logic [AW-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == LAST) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[sweep_addr] <= 8'd0;
    end else if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Ring pointers, fill count and per-request decode.
// ----------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; #(
  parameter int WORDS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  in_item_t                   req,
  input  logic                       cfg_we,
  input  logic [SIZE_W-1:0]          cfg_data,
  output mem_ctl_t                   mem_ctl,
  output logic [$clog2(WORDS)-1:0]   waddr,
  output logic [$clog2(WORDS)-1:0]   raddr,
  output res_info_t                  info
);

  localparam int AW = $clog2(WORDS);
  localparam logic [SIZE_W-1:0] SZ_MAX = SIZE_W'(WORDS);

  logic [SIZE_W-1:0] size_reg;
  logic [AW-1:0]     rp, wp, rp_next, wp_next;
  logic [SIZE_W-1:0] fill, fill_next, sz;
  logic [SIZE_W:0]   peek_sum;
  logic [AW-1:0]     peek_pos;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                            input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] inc;
    inc = (SIZE_W+1)'(p) + 1'b1;
    return (inc >= {1'b0, s}) ? '0 : inc[AW-1:0];
  endfunction

  // Zero acts as one, anything past the store acts as the store size.
  always_comb begin
    if (size_reg == '0)          sz = SIZE_W'(1);
    else if (size_reg > SZ_MAX)  sz = SZ_MAX;
    else                         sz = size_reg;
  end

  // Offset is below fill, so one subtract wraps the peek position.
  always_comb begin
    peek_sum = (SIZE_W+1)'(rp) + (SIZE_W+1)'(req.peek_offset);
    if (peek_sum >= {1'b0, sz}) peek_sum = peek_sum - {1'b0, sz};
    peek_pos = peek_sum[AW-1:0];
  end

  always_comb begin
    rp_next       = rp;
    wp_next       = wp;
    fill_next     = fill;
    mem_ctl       = '0;
    waddr         = wp;
    raddr         = rp;
    info.accepted = 1'b0;
    info.use_mem  = 1'b0;
    unique case (req.opcode)
      OP_PUSH: begin
        if (fill < sz) begin
          mem_ctl.wr    = accept;
          wp_next       = advance(wp, sz);
          fill_next     = fill + 1'b1;
          info.accepted = 1'b1;
        end
      end
      OP_POP: begin
        if (fill != '0) begin
          mem_ctl.rd    = accept;
          rp_next       = advance(rp, sz);
          fill_next     = fill - 1'b1;
          info.accepted = 1'b1;
          info.use_mem  = 1'b1;
        end
      end
      OP_PEEK: begin
        mem_ctl.rd   = accept;
        info.use_mem = 1'b1;
        if (SIZE_W'(req.peek_offset) < fill) begin
          raddr         = peek_pos;
          info.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        rp_next       = '0;
        wp_next       = '0;
        fill_next     = '0;
        info.accepted = 1'b1;
      end
    endcase
    info.fill_count = fill_next;
    info.free_count = sz - fill_next;
    info.is_full    = (fill_next == sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(256);
      rp       <= '0;
      wp       <= '0;
      fill     <= '0;
    end else if (cfg_we) begin
      size_reg <= cfg_data;
      rp       <= '0;
      wp       <= '0;
      fill     <= '0;
    end else if (accept) begin
      rp       <= rp_next;
      wp       <= wp_next;
      fill     <= fill_next;
    end
  end

endmodule

// File: rtl/core/brf_checker.sv
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks for the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker import brf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == OP_CLEAR |=>
      out_data.fill_count == '0 && out_data.accepted && !out_data.is_full)
    else $error("clear left data in ring");

  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_full == (out_data.free_count == '0))
    else $error("full flag and free count disagree");

endmodule

bind byte_ring_fifo_with_peek_top brf_checker u_brf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop, peek and clear requests into the byte ring FIFO under
// changing ring sizes and random handshake idling, and checks each result
// against a cycle-free model of the ring kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench import brf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = 256;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // --------------------------------------------------------------------------
  // Ring model and result checker
  // --------------------------------------------------------------------------
  class fifo_scoreboard;
    logic [7:0]        cells [DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    bit                full;
    logic [SIZE_W-1:0] size_reg;
    out_item_t         expected_q [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned n_push_ok, n_push_full, n_pop_ok, n_pop_empty;
    int unsigned n_peek_hit, n_peek_miss, n_clear, n_full_seen;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      rd_ptr   = 0;
      wr_ptr   = 0;
      full     = 1'b0;
      size_reg = SIZE_W'(256);
    endfunction

    // Register value 0 acts as 1, anything above DEPTH as DEPTH.
    function int unsigned ring_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return 32'(size_reg);
    endfunction

    function int unsigned fill_level();
      int unsigned sz;
      sz = ring_size();
      if (rd_ptr == wr_ptr) return full ? sz : 0;
      if (rd_ptr > wr_ptr) return sz + wr_ptr - rd_ptr;
      return wr_ptr - rd_ptr;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // A size write empties the ring but leaves the stored bytes alone.
    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
      rd_ptr   = 0;
      wr_ptr   = 0;
      full     = 1'b0;
    endfunction

    function void note_request(in_item_t req);
      int unsigned sz;
      int unsigned f;
      int unsigned pos;
      out_item_t   res;
      sz  = ring_size();
      f   = fill_level();
      res = '0;
      case (req.opcode)
        OP_PUSH: begin
          if (f < sz) begin
            cells[wr_ptr] = req.data_in;
            wr_ptr = (wr_ptr + 1 >= sz) ? 0 : wr_ptr + 1;
            if (wr_ptr == rd_ptr) full = 1'b1;
            res.accepted = 1'b1;
            n_push_ok++;
          end else begin
            n_push_full++;
          end
        end
        OP_POP: begin
          if (f > 0) begin
            res.data_out = cells[rd_ptr];
            rd_ptr = (rd_ptr + 1 >= sz) ? 0 : rd_ptr + 1;
            if (wr_ptr == rd_ptr) full = 1'b0;
            res.accepted = 1'b1;
            n_pop_ok++;
          end else begin
            n_pop_empty++;
          end
        end
        OP_PEEK: begin
          // out of range falls back to the byte under the read pointer
          pos = rd_ptr;
          if (req.peek_offset < f) begin
            pos = (rd_ptr + req.peek_offset) % sz;
            res.accepted = 1'b1;
            n_peek_hit++;
          end else begin
            n_peek_miss++;
          end
          res.data_out = cells[pos];
        end
        OP_CLEAR: begin
          rd_ptr = 0;
          wr_ptr = 0;
          full   = 1'b0;
          res.accepted = 1'b1;
          n_clear++;
        end
      endcase
      f = fill_level();
      res.fill_count = SIZE_W'(f);
      res.free_count = SIZE_W'(sz - f);
      res.is_full    = (f == sz);
      if (res.is_full) n_full_seen++;
      expected_q.push_back(res);
    endfunction

    function void field_check(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, got %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      field_check("data_out",   16'(exp_r.data_out),   16'(got.data_out));
      field_check("accepted",   16'(exp_r.accepted),   16'(got.accepted));
      field_check("fill_count", 16'(exp_r.fill_count), 16'(got.fill_count));
      field_check("free_count", 16'(exp_r.free_count), 16'(got.free_count));
      field_check("is_full",    16'(exp_r.is_full),    16'(got.is_full));
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  fifo_scoreboard sb = new();

  int          idle_in_pct   = 0;   // chance per cycle the sender holds off
  int          idle_out_pct  = 0;   // chance per cycle the receiver stalls
  bit          filling       = 1'b1;
  int unsigned sizes_written = 0;
  int unsigned cycle_count   = 0;

  always #5 clk = ~clk;

  byte_ring_fifo_with_peek_top #(.DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Result side: check what was taken at this edge, then pick next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
  end

  // Watchdog; the budget covers the post-reset store sweep many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  function automatic in_item_t make_request(op_t op, logic [7:0] din, logic [7:0] off);
    in_item_t r;
    r.opcode      = op;
    r.data_in     = din;
    r.peek_offset = off;
    return r;
  endfunction

  // Holds valid high after acceptance; the next call either reuses the
  // cycle or drops valid for a gap, so valid never toggles within a step.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_in_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
  endtask

  // Every request yields one result, valid in the cycle after acceptance; the
  // task waits until all results are taken and then lets the block go quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_size(value);
    cfg_wr_en <= 1'b0;
    sizes_written++;
  endtask

  // Random traffic swings between filling and draining so the ring hits
  // both full and empty; refused pushes/pops show up at the turnarounds.
  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned sz;
    int unsigned f;
    int unsigned roll;
    sz = sb.ring_size();
    f  = sb.fill_level();
    if (f == sz) filling = 1'b0;
    else if (f == 0) filling = 1'b1;
    roll          = $urandom_range(0, 99);
    r.data_in     = 8'($urandom_range(0, 255));
    r.peek_offset = 8'($urandom_range(0, 255));
    if (f > 0 && $urandom_range(0, 1)) r.peek_offset = 8'($urandom_range(0, f - 1));
    if (roll < 2 && !filling)  r.opcode = OP_CLEAR;
    else if (roll < 16)        r.opcode = OP_PEEK;
    else if (roll < 89)        r.opcode = filling ? OP_PUSH : OP_POP;
    else                       r.opcode = filling ? OP_POP : OP_PUSH;
    return r;
  endfunction

  task automatic run_phase(input logic [SIZE_W-1:0] size_val, input int unsigned count);
    write_size(size_val);
    repeat (count) send_request(random_request());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: full size from reset, empty-ring refusals and stale peeks.
    send_request(make_request(OP_POP,   8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));
    send_request(make_request(OP_PUSH,  8'h00, 8'h00));
    send_request(make_request(OP_PUSH,  8'hFF, 8'hFF));
    send_request(make_request(OP_PUSH,  8'h5A, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h02));
    send_request(make_request(OP_PEEK,  8'h00, 8'h03));  // just past the fill
    send_request(make_request(OP_PEEK,  8'hFF, 8'hFF));
    send_request(make_request(OP_POP,   8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));
    send_request(make_request(OP_CLEAR, 8'hFF, 8'hFF));
    send_request(make_request(OP_POP,   8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));

    // One-cell ring: full after a single push, refused second push.
    write_size(SIZE_W'(1));
    send_request(make_request(OP_PUSH,  8'hC3, 8'h00));
    send_request(make_request(OP_PUSH,  8'h11, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h01));
    send_request(make_request(OP_POP,   8'h00, 8'h00));
    send_request(make_request(OP_POP,   8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h00));  // stale byte, empty ring

    // Size zero behaves as one; clear keeps the stored byte visible.
    write_size(SIZE_W'(0));
    send_request(make_request(OP_PUSH,  8'h7E, 8'h00));
    send_request(make_request(OP_CLEAR, 8'h00, 8'h00));
    send_request(make_request(OP_PEEK,  8'h00, 8'h05));

    // Random traffic, sender idling lightly and receiver heavily.
    idle_in_pct  = 17;
    idle_out_pct = 64;
    run_phase(SIZE_W'(256), 460);
    run_phase(SIZE_W'(1),   16);
    run_phase(SIZE_W'(0),   12);
    run_phase(SIZE_W'(2),   22);

    // Roles swapped; all-ones size clamps to the full store.
    idle_in_pct  = 64;
    idle_out_pct = 17;
    run_phase(SIZE_W'(SIZE_MAX), 460);
    run_phase(SIZE_W'(3),        20);
    run_phase(SIZE_W'(7),        30);

    // Back to back, no idling on either side.
    idle_in_pct  = 0;
    idle_out_pct = 0;
    run_phase(SIZE_W'(257), 300);
    run_phase(SIZE_W'(64),  130);
    run_phase(SIZE_W'(17),  60);
    run_phase(SIZE_W'(5),   20);

    wait_drained();
    repeat (5) @(posedge clk);

    $display("Checked %0d results, %0d size writes; push %0d ok/%0d full, pop %0d ok/%0d empty",
             sb.checked, sizes_written, sb.n_push_ok, sb.n_push_full, sb.n_pop_ok,
             sb.n_pop_empty);
    $display("Peeks %0d in range / %0d out of range, %0d clears, ring full %0d times",
             sb.n_peek_hit, sb.n_peek_miss, sb.n_clear, sb.n_full_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/brf_pkg.sv
rtl/core/brf_store.sv
rtl/core/brf_ctrl.sv
rtl/core/byte_ring_fifo_with_peek_top.sv
rtl/core/brf_checker.sv
test/testbench.sv
